// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== hw/rtl/hrht_pkg.sv =====
// Package for the HTTP request header tokenizer: codes, types, defaults.
// No dependencies; imported by every module of the block.
`default_nettype none

package hrht_pkg;

	localparam int LEN_BITS_DEF    = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_METHOD = 3'd1;
	localparam logic [2:0] KIND_PATH   = 3'd2;
	localparam logic [2:0] KIND_PROTO  = 3'd3;
	localparam logic [2:0] KIND_NAME   = 3'd4;
	localparam logic [2:0] KIND_VALUE  = 3'd5;

	localparam logic [3:0] ST_RUNNING     = 4'd0;
	localparam logic [3:0] ST_SUCCESS     = 4'd1;
	localparam logic [3:0] ST_METHOD_LONG = 4'd2;
	localparam logic [3:0] ST_PATH_LONG   = 4'd3;
	localparam logic [3:0] ST_PROTO_LONG  = 4'd4;
	localparam logic [3:0] ST_TOO_MANY    = 4'd5;
	localparam logic [3:0] ST_NAME_LONG   = 4'd6;
	localparam logic [3:0] ST_VALUE_LONG  = 4'd7;
	localparam logic [3:0] ST_MISMATCH    = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_METHOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PATH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PROTO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_NAME    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HEADERS = 3'd5;

	localparam logic [7:0]  RST_MAX_METHOD  = 8'd16;
	localparam logic [15:0] RST_MAX_PATH    = 16'd2048;
	localparam logic [7:0]  RST_MAX_PROTO   = 8'd16;
	localparam logic [7:0]  RST_MAX_NAME    = 8'd64;
	localparam logic [15:0] RST_MAX_VALUE   = 16'd1024;
	localparam logic [7:0]  RST_MAX_HEADERS = 8'd32;

	typedef enum logic [1:0] {PH_HEADLINE, PH_HEADERS} phase_t;
	typedef enum logic [1:0] {HP_METHOD, HP_PATH, HP_PROTO} part_t;
	typedef enum logic [1:0] {LF_NONE, LF_LINE, LF_END} lf_t;

	typedef struct packed {
		logic is_sp;
		logic is_cr;
		logic is_lf;
		logic is_colon;
	} class_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		class_t     cls;
	} item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hrht_front.sv =====
// Front end: takes input words, classifies the delimiter bytes, registers them.
// Depends on hrht_pkg; feeds hrht_queue.
`default_nettype none

module hrht_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    in_data,
	input  wire logic                          in_first,
	input  wire logic                          in_last,
	output logic                               push,
	input  wire logic                          push_ready,
	output hrht_pkg::item_t                    push_item
);
	import hrht_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_c;

	always_comb begin
		item_c.data         = in_data;
		item_c.first        = in_first;
		item_c.last         = in_last;
		item_c.cls.is_sp    = (in_data == CH_SPACE);
		item_c.cls.is_cr    = (in_data == CH_CR);
		item_c.cls.is_lf    = (in_data == CH_LF);
		item_c.cls.is_colon = (in_data == CH_COLON);
	end

	assign in_ready  = !valid_s1 || push_ready;
	assign push      = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hrht_queue.sv =====
// Short queue of classified bytes between the front end and the parser.
// Depends on hrht_pkg for the item type.
`default_nettype none

module hrht_queue #(
	parameter int DEPTH = hrht_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 push_ready,
	input  wire hrht_pkg::item_t push_item,
	output logic                 pop_valid,
	input  wire logic            pop,
	output hrht_pkg::item_t      pop_item
);
	import hrht_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slots_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && push_ready) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if ((push && push_ready) && !(pop && pop_valid)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && push_ready) && (pop && pop_valid)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(DEPTH))
	`ASSERT_PROP(a_pop_nonempty, clk, arst_n, pop |-> pop_valid)
	`ASSERT_PROP(a_count_track, clk, arst_n, (push && push_ready && !pop) |=> count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

// ===== hw/rtl/hrht_back.sv =====
// Back end: parser state, limit registers and the registered result word.
// Depends on hrht_pkg; pops from hrht_queue.
`default_nettype none

module hrht_back #(
	parameter int LEN_BITS = hrht_pkg::LEN_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pop_valid,
	output logic                                   pop,
	input  wire hrht_pkg::item_t                   pop_item,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [hrht_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [hrht_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             out_byte,
	output logic [2:0]                             out_field_kind,
	output logic [2:0]                             out_closed_kind,
	output logic [15:0]                            out_closed_len,
	output logic [7:0]                             out_header_index,
	output logic [3:0]                             out_status
);
	import hrht_pkg::*;

	`include "assert_macros.svh"

	localparam int CW = (LEN_BITS > 16) ? LEN_BITS : 16;

	logic [7:0]  max_method_q, max_proto_q, max_name_q, max_headers_q;
	logic [15:0] max_path_q, max_value_q;

	phase_t              phase_q, c_phase, n_phase;
	part_t               part_q, c_part, n_part;
	logic                in_value_q, c_in_value, n_in_value;
	logic [LEN_BITS-1:0] flen_q, c_flen, n_flen, flen_grow;
	logic [7:0]          hseen_q, c_hseen, n_hseen;
	lf_t                 elf_q, c_elf, n_elf;
	logic                skip_q, c_skip, n_skip;
	logic [3:0]          fstat_q, c_fstat, n_fstat;

	logic [CW-1:0] flen_ext, lim, clen_w;
	logic [2:0]    kind, ckind, part_kind;
	logic [3:0]    part_err;
	logic [7:0]    idx;
	logic [15:0]   clen_sat;
	logic          out_valid_q;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign pop       = pop_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_method_q  <= RST_MAX_METHOD;
			max_path_q    <= RST_MAX_PATH;
			max_proto_q   <= RST_MAX_PROTO;
			max_name_q    <= RST_MAX_NAME;
			max_value_q   <= RST_MAX_VALUE;
			max_headers_q <= RST_MAX_HEADERS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_METHOD:  max_method_q  <= cfg_data[7:0];
				REG_MAX_PATH:    max_path_q    <= cfg_data;
				REG_MAX_PROTO:   max_proto_q   <= cfg_data[7:0];
				REG_MAX_NAME:    max_name_q    <= cfg_data[7:0];
				REG_MAX_VALUE:   max_value_q   <= cfg_data;
				REG_MAX_HEADERS: max_headers_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pop_item.first) begin
			c_phase    = PH_HEADLINE;
			c_part     = HP_METHOD;
			c_in_value = 1'b0;
			c_flen     = '0;
			c_hseen    = '0;
			c_elf      = LF_NONE;
			c_skip     = 1'b0;
			c_fstat    = ST_RUNNING;
		end else begin
			c_phase    = phase_q;
			c_part     = part_q;
			c_in_value = in_value_q;
			c_flen     = flen_q;
			c_hseen    = hseen_q;
			c_elf      = elf_q;
			c_skip     = skip_q;
			c_fstat    = fstat_q;
		end
	end

	assign flen_ext  = CW'(c_flen);
	assign flen_grow = (c_flen == '1) ? c_flen : c_flen + 1'b1;

	always_comb begin
		case (c_part)
			HP_METHOD: begin
				lim       = CW'(max_method_q);
				part_kind = KIND_METHOD;
				part_err  = ST_METHOD_LONG;
			end
			HP_PATH: begin
				lim       = CW'(max_path_q);
				part_kind = KIND_PATH;
				part_err  = ST_PATH_LONG;
			end
			default: begin
				lim       = CW'(max_proto_q);
				part_kind = KIND_PROTO;
				part_err  = ST_PROTO_LONG;
			end
		endcase
	end

	always_comb begin
		n_phase    = c_phase;
		n_part     = c_part;
		n_in_value = c_in_value;
		n_flen     = c_flen;
		n_hseen    = c_hseen;
		n_elf      = c_elf;
		n_skip     = c_skip;
		n_fstat    = c_fstat;
		kind       = KIND_NONE;
		ckind      = KIND_NONE;
		clen_w     = '0;
		idx        = c_hseen;
		if (c_fstat != ST_RUNNING) begin
			n_fstat = c_fstat;
		end else if (c_elf != LF_NONE) begin
			if (!pop_item.cls.is_lf) begin
				n_fstat = ST_MISMATCH;
			end else if (c_elf == LF_END) begin
				n_fstat = ST_SUCCESS;
			end
			n_elf = LF_NONE;
		end else if (c_skip && pop_item.cls.is_sp) begin
			n_skip = 1'b0;
		end else if (c_phase == PH_HEADLINE) begin
			n_skip = 1'b0;
			if (pop_item.cls.is_sp || pop_item.cls.is_cr) begin
				if (flen_ext >= lim) begin
					n_fstat = part_err;
				end else begin
					ckind  = part_kind;
					clen_w = flen_ext;
					n_flen = '0;
					case (c_part)
						HP_METHOD: n_part = HP_PATH;
						HP_PATH:   n_part = HP_PROTO;
						default: begin
							n_part  = HP_PROTO;
							n_phase = PH_HEADERS;
						end
					endcase
					if (pop_item.cls.is_cr) begin
						n_elf = LF_LINE;
					end
				end
			end else begin
				kind   = part_kind;
				n_flen = flen_grow;
			end
		end else begin
			n_skip = 1'b0;
			if (!c_in_value && pop_item.cls.is_cr) begin
				n_flen = '0;
				n_elf  = LF_END;
			end else if (!c_in_value && pop_item.cls.is_colon) begin
				if (c_hseen >= max_headers_q) begin
					n_fstat = ST_TOO_MANY;
				end else if (flen_ext >= CW'(max_name_q)) begin
					n_fstat = ST_NAME_LONG;
				end else begin
					ckind      = KIND_NAME;
					clen_w     = flen_ext;
					n_flen     = '0;
					n_in_value = 1'b1;
					n_skip     = 1'b1;
				end
			end else if (c_in_value && pop_item.cls.is_cr) begin
				if (flen_ext >= CW'(max_value_q)) begin
					n_fstat = ST_VALUE_LONG;
				end else begin
					ckind      = KIND_VALUE;
					clen_w     = flen_ext;
					n_flen     = '0;
					n_in_value = 1'b0;
					n_hseen    = c_hseen + 8'(c_hseen != 8'hFF);
					n_elf      = LF_LINE;
				end
			end else begin
				kind   = c_in_value ? KIND_VALUE : KIND_NAME;
				n_flen = flen_grow;
			end
		end
		if (n_fstat == ST_RUNNING && pop_item.last) begin
			n_fstat = ST_MISMATCH;
		end
		if (n_fstat > ST_SUCCESS) begin
			kind   = KIND_NONE;
			ckind  = KIND_NONE;
			clen_w = '0;
		end
		if (n_fstat == ST_SUCCESS) begin
			idx = n_hseen;
		end
	end

	assign clen_sat = (clen_w > CW'(16'hFFFF)) ? 16'hFFFF : clen_w[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADLINE;
			part_q      <= HP_METHOD;
			in_value_q  <= 1'b0;
			flen_q      <= '0;
			hseen_q     <= '0;
			elf_q       <= LF_NONE;
			skip_q      <= 1'b0;
			fstat_q     <= ST_RUNNING;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q    <= n_phase;
				part_q     <= n_part;
				in_value_q <= n_in_value;
				flen_q     <= n_flen;
				hseen_q    <= n_hseen;
				elf_q      <= n_elf;
				skip_q     <= n_skip;
				fstat_q    <= n_fstat;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte         <= pop_item.data;
			out_field_kind   <= kind;
			out_closed_kind  <= ckind;
			out_closed_len   <= clen_sat;
			out_header_index <= idx;
			out_status       <= n_fstat;
		end
	end

	`ASSERT_PROP(a_err_quiet, clk, arst_n, (out_valid_q && out_status > ST_SUCCESS) |-> (out_field_kind == KIND_NONE && out_closed_kind == KIND_NONE))
	`ASSERT_PROP(a_len_needs_close, clk, arst_n, (out_valid_q && out_closed_len != 16'd0) |-> out_closed_kind != KIND_NONE)
	`ASSERT_PROP(a_status_hold, clk, arst_n, (pop && !pop_item.first && fstat_q != ST_RUNNING) |=> fstat_q == $past(fstat_q))

endmodule

`default_nettype wire

// ===== hw/rtl/http_request_header_tokenizer_top.sv =====
// Top level of the HTTP request header tokenizer.
// Depends on hrht_pkg, hrht_front, hrht_queue and hrht_back.
//
// channel  dir  handshake              payload
// s_axis   in   tvalid/tready          tdata=in_byte, tuser=first_byte, tlast=last_byte
// m_axis   out  tvalid/tready          tdata=result word, tuser=field_kind
// cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One word per cycle while m_axis_tready is high; hrht_back updates state per byte.
// Registers on the path: hrht_front stage, queue slot, hrht_back outputs.
// Reset clears all control state and restores the limit registers.
// The queue lets input keep flowing while the result side is stalled, until full.
`default_nettype none

module http_request_header_tokenizer_top #(
	parameter int LEN_BITS    = hrht_pkg::LEN_BITS_DEF,
	parameter int QUEUE_DEPTH = hrht_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [hrht_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] in_byte
	input  wire logic                               s_axis_tuser,  // [0] first_byte
	input  wire logic                               s_axis_tlast,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [7:0] out_byte, [10:8] closed_kind, [26:11] closed_len,
	// [34:27] header_index, [38:35] status, [39] zero
	output logic [hrht_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	output logic [2:0]                              m_axis_tuser,  // [2:0] field_kind
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [hrht_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [hrht_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import hrht_pkg::*;

	logic        push, push_ready, pop_valid, pop;
	item_t       push_item, pop_item;
	logic [7:0]  out_byte, out_header_index;
	logic [2:0]  out_closed_kind;
	logic [15:0] out_closed_len;
	logic [3:0]  out_status;

	hrht_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_first   (s_axis_tuser),
		.in_last    (s_axis_tlast),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	hrht_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	hrht_back #(
		.LEN_BITS (LEN_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_valid        (pop_valid),
		.pop              (pop),
		.pop_item         (pop_item),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_byte         (out_byte),
		.out_field_kind   (m_axis_tuser),
		.out_closed_kind  (out_closed_kind),
		.out_closed_len   (out_closed_len),
		.out_header_index (out_header_index),
		.out_status       (out_status)
	);

	assign m_axis_tdata = {1'b0, out_status, out_header_index, out_closed_len,
		out_closed_kind, out_byte};

endmodule

`default_nettype wire
